// File: rtl/dfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

	// Frame store geometry
	localparam int BUF_DEPTH = 32;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

	// Character codes
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// Register reset values
	localparam logic [7:0] STOP_RESET  = 8'd10;
	localparam logic [7:0] START_RESET = 8'd2;
	localparam logic       MODE_RESET  = 1'b0;
	localparam logic       RECV_RESET  = 1'b1;

	// Register map: index i at byte address 4*i
	localparam int          APB_ADDR_W = 4;
	localparam logic [1:0]  REG_STOP   = 2'd0;
	localparam logic [1:0]  REG_START  = 2'd1;
	localparam logic [1:0]  REG_MODE   = 2'd2;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_TIMEOUT = 2'd1,
		ACT_READ    = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_NEXT
	} state_t;

	typedef struct packed {
		logic [7:0] stop_symbol;
		logic [7:0] start_symbol;
		logic       start_mode;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/dfr_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dfr_rx_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;

	modport source (output valid, action, rx_byte, input ready);
	modport sink (input valid, action, rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/dfr_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dfr_res_if;
	logic       valid;
	logic       ready;
	logic       frame_status;
	logic       char_valid;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, frame_status, char_valid, char_out, last, input ready);
	modport sink (input valid, frame_status, char_valid, char_out, last, output ready);
endinterface

`default_nettype wire

// File: rtl/dfr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module dfr_cfg
	import dfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_symbol  <= STOP_RESET;
			cfg_q.start_symbol <= START_RESET;
			cfg_q.start_mode   <= MODE_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STOP:  cfg_q.stop_symbol  <= pwdata[7:0];
				REG_START: cfg_q.start_symbol <= pwdata[7:0];
				REG_MODE:  cfg_q.start_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		unique case (reg_idx)
			REG_STOP:  prdata = {24'd0, cfg_q.stop_symbol};
			REG_START: prdata = {24'd0, cfg_q.start_symbol};
			REG_MODE:  prdata = {31'd0, cfg_q.start_mode};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/delimited_frame_receiver.sv
// Delimited frame receiver.
// Items enter on the rx channel (action, rx_byte) and results leave on the res
// channel (frame_status, char_valid, char_out, last); both use valid/ready and
// move an item when both are high. Registers sit behind an APB port.
// Byte, timeout and release items give one result, registered: it shows in the
// cycle after the item is taken, and such items can be taken every cycle while
// the result side keeps up, since the output register frees as it is taken.
// A read item streams the stored characters from a 32 x 8 synchronous memory
// with one write port and one registered read port and one-entry lookahead:
// ST_RD_FIRST holds the first entry and fetches the next, then ST_RD_NEXT
// emits one character per cycle while the result side keeps up; the input
// takes no new item until the read has ended.
// Reset clears the count, status and per-entry valid bits at once, so the
// store reads as all zero with no clearing pass; reception starts enabled.
// When the result side stalls, the output register holds its item, the
// stream pauses in place and no new item is taken until it frees.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_receiver
	import dfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dfr_rx_if.sink                     rx,
	dfr_res_if.source                  res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	cfg_t cfg;

	dfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Control state
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     fill_q, fill_d;
	logic                 recv_q, recv_d;
	logic                 got_q, got_d;
	logic [BUF_DEPTH-1:0] valid_q, valid_d;
	logic                 spaced_q, spaced_d;
	logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
	logic [7:0]           cur_q, cur_d;

	// Frame store
	logic [7:0]        mem_q [BUF_DEPTH];
	logic [7:0]        rdata_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata;

	// Output register
	logic       res_valid_q;
	logic       out_load;
	logic       out_status, out_cv, out_last;
	logic [7:0] out_ch;
	logic       st_q, cv_q, last_q;
	logic [7:0] ch_q;
	logic       out_free;

	// Helpers
	action_t          act;
	logic [7:0]       sym;
	logic             at_end;
	logic [7:0]       eff;
	logic [CNT_W-1:0] rd_nxt;

	assign act      = action_t'(rx.action);
	assign sym      = (act == ACT_TIMEOUT) ? cfg.stop_symbol : rx.rx_byte;
	assign out_free = !res_valid_q || res.ready;
	assign at_end   = (rd_idx_q == CNT_W'(BUF_DEPTH));
	assign rd_nxt   = rd_idx_q + CNT_W'(1);

	// Entry value: written data, else space after a read (not entry 0), else zero
	always_comb begin
		if (at_end) begin
			eff = NUL_CHAR;
		end else if (valid_q[rd_idx_q[ADDR_W-1:0]]) begin
			eff = rdata_q;
		end else if (spaced_q && rd_idx_q != '0) begin
			eff = SPACE_CHAR;
		end else begin
			eff = NUL_CHAR;
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// Next state and outputs
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		recv_d     = recv_q;
		got_d      = got_q;
		valid_d    = valid_q;
		spaced_d   = spaced_q;
		rd_idx_d   = rd_idx_q;
		cur_d      = cur_q;
		mem_we     = 1'b0;
		mem_waddr  = fill_q[ADDR_W-1:0];
		mem_wdata  = NUL_CHAR;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		out_load   = 1'b0;
		out_status = got_q;
		out_cv     = 1'b0;
		out_ch     = NUL_CHAR;
		out_last   = 1'b1;
		rx.ready   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				rx.ready = out_free;
				if (rx.valid && out_free) begin
					unique case (act) inside
						ACT_BYTE, ACT_TIMEOUT: begin
							if (recv_q) begin
								if (sym == cfg.stop_symbol || fill_q >= CNT_W'(BUF_DEPTH)) begin
									// terminate frame; no terminator slot when full
									if (fill_q < CNT_W'(BUF_DEPTH)) begin
										mem_we                          = 1'b1;
										mem_wdata                       = NUL_CHAR;
										valid_d[fill_q[ADDR_W-1:0]] = 1'b1;
									end
									recv_d = 1'b0;
									fill_d = '0;
									got_d  = 1'b1;
								end else begin
									mem_we                          = 1'b1;
									mem_wdata                       = sym;
									valid_d[fill_q[ADDR_W-1:0]] = 1'b1;
									fill_d                          = fill_q + CNT_W'(1);
								end
							end
							if (cfg.start_mode && sym == cfg.start_symbol) begin
								recv_d = 1'b1;
							end
							out_load   = 1'b1;
							out_status = got_d;
						end
						ACT_READ: begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							rd_idx_d  = '0;
							state_d   = ST_RD_FIRST;
						end
						ACT_RELEASE: begin
							got_d      = 1'b0;
							recv_d     = 1'b1;
							out_load   = 1'b1;
							out_status = 1'b0;
						end
					endcase
				end
			end

			ST_RD_FIRST: begin
				if (eff == NUL_CHAR) begin
					// empty frame: single marker result
					if (out_free) begin
						out_load   = 1'b1;
						valid_d    = '0;
						valid_d[0] = valid_q[0];
						spaced_d   = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cur_d     = eff;
					rd_idx_d  = rd_nxt;
					mem_re    = 1'b1;
					mem_raddr = rd_nxt[ADDR_W-1:0];
					state_d   = ST_RD_NEXT;
				end
			end

			ST_RD_NEXT: begin
				// emit held char; lookahead entry decides last
				if (out_free) begin
					out_load = 1'b1;
					out_cv   = 1'b1;
					out_ch   = cur_q;
					out_last = at_end || eff == NUL_CHAR;
					if (at_end || eff == NUL_CHAR) begin
						valid_d    = '0;
						valid_d[0] = valid_q[0];
						spaced_d   = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cur_d     = eff;
						rd_idx_d  = rd_nxt;
						mem_re    = (rd_nxt != CNT_W'(BUF_DEPTH));
						mem_raddr = rd_nxt[ADDR_W-1:0];
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			recv_q   <= RECV_RESET;
			got_q    <= 1'b0;
			valid_q  <= '0;
			spaced_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			fill_q   <= fill_d;
			recv_q   <= recv_d;
			got_q    <= got_d;
			valid_q  <= valid_d;
			spaced_q <= spaced_d;
			rd_idx_q <= rd_idx_d;
		end
	end

	// Lookahead character
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			st_q   <= out_status;
			cv_q   <= out_cv;
			ch_q   <= out_ch;
			last_q <= out_last;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.frame_status = st_q;
	assign res.char_valid   = cv_q;
	assign res.char_out     = ch_q;
	assign res.last         = last_q;

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(BUF_DEPTH))
		else $error("fill count beyond buffer depth");

	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !mem_we)
		else $error("store written during frame read");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && act == ACT_RELEASE) |=> (!got_q && recv_q))
		else $error("release did not clear status and enable reception");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_d == ST_IDLE) |=>
			(spaced_q && valid_q[BUF_DEPTH-1:1] == '0))
		else $error("read end did not space-fill the store");

	a_nonlast_char: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last) |-> res.char_valid)
		else $error("non-final result without a character");

endmodule

`default_nettype wire
